### sv/mav_pkg.sv
// ---------------------------------------------------------------------------
// mav_pkg
// Shared widths, constants, codes and state types of the gas ppm block.
// ---------------------------------------------------------------------------
package mav_pkg;

    localparam int DEF_WINDOW   = 5;
    localparam int DEF_ADC_BITS = 12;

    localparam int SAMPLE_W   = 12;
    localparam int PPM_W      = 15;
    localparam int CLAMP_W    = 2;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam int REF_W = 13;
    localparam int RL_W  = 17;
    localparam int R0_W  = 20;

    localparam int REF_RESET = 3300;
    localparam int RL_RESET  = 10000;
    localparam int R0_RESET  = 76630;

    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DIV_W    = 36;
    localparam int DVS_W    = 10;
    localparam int FRAC_W   = 16;
    localparam int LG_STEPS = 16;

    localparam int PPM_LO_X16 = 160;
    localparam int PPM_HI_X16 = 32000;
    localparam int PPM_K_X160 = 18656;
    localparam int PPM_K_DIV  = 10;
    localparam int EXP_NUM    = 2769;
    localparam int EXP_DEN    = 1000;

    localparam logic [CLAMP_W-1:0] CLAMP_IN   = 2'd0;
    localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd1;
    localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_MV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAN  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG,
        ST_CHK,
        ST_NUM,
        ST_DEN,
        ST_SPEC,
        ST_LGN,
        ST_LGD,
        ST_SCL,
        ST_QDIV,
        ST_RANGE,
        ST_BS,
        ST_BSC,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQ,
        LG_WAIT
    } t_lg_state;

    // log2 in q16 by repeated squaring, for elaboration-time constants
    function automatic logic [31:0] f_lg_q16(input logic [63:0] x);
        logic [5:0]  n;
        logic [63:0] m;
        logic [15:0] frac;
        n = '0;
        for (int i = 1; i < 64; i++) begin
            if ((x >> i) != 64'd0) begin
                n = 6'(i);
            end
        end
        if (n <= 6'd31) begin
            m = x << (6'd31 - n);
        end else begin
            m = x >> (n - 6'd31);
        end
        frac = '0;
        for (int k = 0; k < 16; k++) begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m[32]) begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return {10'd0, n, frac};
    endfunction

endpackage

### sv/mav_mul.sv
// ---------------------------------------------------------------------------
// mav_mul
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module mav_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mav_pkg::MUL_W-1:0]   i_a,
    input  logic [mav_pkg::MUL_W-1:0]   i_b,
    output logic                        o_done,
    output logic [mav_pkg::PROD_W-1:0]  o_p
);
    import mav_pkg::*;

    localparam int CNT_W = $clog2(MUL_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MUL_W-1:0] r_a;
    logic [MUL_W-1:0] r_hi;
    logic [MUL_W-1:0] r_lo;
    logic [MUL_W:0]   n_sum;

    assign n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(MUL_W + 1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_hi <= n_sum[MUL_W:1];
            r_lo <= {n_sum[0], r_lo[MUL_W-1:1]};
        end else if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end
    end

    assign o_done = r_done;
    assign o_p    = {r_hi, r_lo};

endmodule

### sv/mav_div.sv
// ---------------------------------------------------------------------------
// mav_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mav_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mav_pkg::DIV_W-1:0]  i_dividend,
    input  logic [mav_pkg::DVS_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [mav_pkg::DIV_W-1:0]  o_q
);
    import mav_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_d;
    logic [DVS_W:0]   n_t;
    logic [DVS_W:0]   n_diff;
    logic             n_ge;

    assign n_t    = {r_rem, r_q[DIV_W-1]};
    assign n_ge   = n_t >= {1'b0, r_d};
    assign n_diff = n_t - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= n_ge ? n_diff[DVS_W-1:0] : n_t[DVS_W-1:0];
            r_q   <= {r_q[DIV_W-2:0], n_ge};
        end else if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_d   <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

### sv/mav_lg.sv
// ---------------------------------------------------------------------------
// mav_lg
// Fixed-point log2 in q16: serial normalize, then sixteen mantissa squarings.
// ---------------------------------------------------------------------------
module mav_lg #(
    parameter int IN_W = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic [IN_W-1:0]                          i_x,
    output logic                                     o_done,
    output logic [$clog2(IN_W)+mav_pkg::FRAC_W-1:0]  o_lg
);
    import mav_pkg::*;

    localparam int NB    = $clog2(IN_W);
    localparam int K_W   = $clog2(LG_STEPS);

    t_lg_state         r_state;
    t_lg_state         n_state;
    logic              r_done;
    logic [IN_W-1:0]   r_x;
    logic [NB-1:0]     r_n;
    logic [MUL_W-1:0]  r_m;
    logic [FRAC_W-1:0] r_frac;
    logic [K_W-1:0]    r_k;
    logic              n_last;
    logic              mul_start;
    logic              mul_done;
    logic [PROD_W-1:0] mul_p;
    logic [MUL_W:0]    n_t;

    mav_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_m),
        .i_b     (r_m),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    assign n_t    = mul_p[PROD_W-1:MUL_W-1];
    assign n_last = (r_k == K_W'(LG_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            LG_IDLE: begin
                if (i_start) n_state = LG_NORM;
            end
            LG_NORM: begin
                if (r_x[IN_W-1]) n_state = LG_SQ;
            end
            LG_SQ: begin
                n_state = LG_WAIT;
            end
            LG_WAIT: begin
                if (mul_done) n_state = n_last ? LG_IDLE : LG_SQ;
            end
            default: begin
                n_state = LG_IDLE;
            end
        endcase
    end

    always_comb begin
        mul_start = (r_state == LG_SQ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LG_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == LG_WAIT) && mul_done && n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            LG_IDLE: begin
                if (i_start) begin
                    r_x <= i_x;
                    r_n <= NB'(IN_W - 1);
                end
            end
            LG_NORM: begin
                if (r_x[IN_W-1]) begin
                    r_m    <= r_x[IN_W-1 -: MUL_W];
                    r_k    <= '0;
                    r_frac <= '0;
                end else begin
                    r_x <= r_x << 1;
                    r_n <= r_n - 1'b1;
                end
            end
            LG_WAIT: begin
                if (mul_done) begin
                    r_frac <= {r_frac[FRAC_W-2:0], n_t[MUL_W]};
                    r_m    <= n_t[MUL_W] ? n_t[MUL_W:1] : n_t[MUL_W-1:0];
                    r_k    <= r_k + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_lg   = {r_n, r_frac};

endmodule

### sv/moving_average_gas_ppm.sv
// Moving average of ADC samples with power-law gas calibration. Each sample
// enters a WINDOW-deep ring (cleared at reset) and one result follows per
// sample: the truncated window mean, the concentration as ppm*16 clamped to
// 10..2000 ppm, and a clamp code. One sample is processed at a time; its
// run time is set by the bit-serial 32x32 multiplier inside the log2 unit:
// each log2 costs sixteen squarings, and a sample needs two log2 evaluations
// for the resistance ratio plus up to fifteen for the binary search of the
// output. A zero ratio or a zero clean resistance finishes before any log2,
// and a result clamped by the range check skips the binary search. A
// finished result sits in an output register, so the next sample is taken
// while it waits.
// ---------------------------------------------------------------------------
// moving_average_gas_ppm
// Sample window filter and ppm calibration, serial arithmetic datapath.
// ---------------------------------------------------------------------------
module moving_average_gas_ppm #(
    parameter int WINDOW   = mav_pkg::DEF_WINDOW,
    parameter int ADC_BITS = mav_pkg::DEF_ADC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [mav_pkg::S_DATA_W-1:0]       i_s_tdata,   // sample
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [mav_pkg::M_DATA_W-1:0]       o_m_tdata,   // avg_count, ppm_x16, clamp_state
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mav_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mav_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mav_pkg::*;

    localparam int FS      = (1 << ADC_BITS) - 1;
    localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW + 1);
    localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int LG_IN_W = (ADC_BITS + RL_W > SAMPLE_W + R0_W) ?
                             (ADC_BITS + RL_W) : (SAMPLE_W + R0_W);
    localparam int LG_W    = $clog2(LG_IN_W) + FRAC_W;
    localparam int L_W     = DIV_W + 1;

    localparam logic signed [L_W-1:0] C0_L =
        $signed(L_W'(f_lg_q16(64'(PPM_K_X160)))) - $signed(L_W'(f_lg_q16(64'(PPM_K_DIV))));
    localparam logic signed [L_W-1:0] LO_L = $signed(L_W'(f_lg_q16(64'(PPM_LO_X16))));
    localparam logic signed [L_W-1:0] HI_L = $signed(L_W'(f_lg_q16(64'(PPM_HI_X16))));

    t_state r_state;
    t_state n_state;
    logic   r_issued;
    logic   launch;

    logic [REF_W-1:0] r_ref;
    logic [RL_W-1:0]  r_rl;
    logic [R0_W-1:0]  r_r0;

    logic [SAMPLE_W-1:0] r_win [WINDOW];
    logic [POS_W-1:0]    r_pos;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] n_sample;

    logic [SAMPLE_W-1:0]    r_avg;
    logic                   r_floor;
    logic [LG_IN_W-1:0]     r_num;
    logic [LG_IN_W-1:0]     r_den;
    logic [LG_W-1:0]        r_lgn;
    logic signed [LG_W:0]   r_lr;
    logic [DIV_W-1:0]       r_prod;
    logic signed [L_W-1:0]  r_l;
    logic [PPM_W-1:0]       r_lo;
    logic [PPM_W-1:0]       r_hi;
    logic [PPM_W-1:0]       r_ppm;
    logic [CLAMP_W-1:0]     r_clamp;

    logic                r_m_valid;
    logic [SAMPLE_W-1:0] r_o_avg;
    logic [PPM_W-1:0]    r_o_ppm;
    logic [CLAMP_W-1:0]  r_o_clamp;

    logic                  s_accept;
    logic                  out_free;
    logic [PPM_W:0]        n_mid_sum;
    logic [PPM_W-1:0]      n_mid;
    logic [LG_W:0]         n_abs;
    logic signed [LG_W:0]  n_lr;
    logic signed [L_W-1:0] n_qs;
    logic signed [L_W-1:0] n_lval;
    logic                  n_le;
    logic [REF_W-1:0]      n_refm1;
    logic [ADC_BITS-1:0]   n_fsavg;

    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_q;
    logic              mul_start;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic              mul_done;
    logic [PROD_W-1:0] mul_p;
    logic              lg_start;
    logic [LG_IN_W-1:0] lg_x;
    logic              lg_done;
    logic [LG_W-1:0]   lg_out;

    mav_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_q        (div_q)
    );

    mav_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    mav_lg #(
        .IN_W (LG_IN_W)
    ) u_lg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lg_start),
        .i_x     (lg_x),
        .o_done  (lg_done),
        .o_lg    (lg_out)
    );

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign out_free    = !r_m_valid || i_m_tready;
    assign launch      = !r_issued;

    assign n_sample  = i_s_tdata[SAMPLE_W-1:0] & SAMPLE_W'(FS);
    assign n_mid_sum = {1'b0, r_lo} + {1'b0, r_hi} + (PPM_W + 1)'(1);
    assign n_mid     = n_mid_sum[PPM_W:1];
    assign n_abs     = r_lr[LG_W] ? $unsigned(-r_lr) : $unsigned(r_lr);
    assign n_lr      = $signed({1'b0, r_lgn}) - $signed({1'b0, lg_out});
    assign n_qs      = $signed({1'b0, div_q});
    assign n_lval    = C0_L - (r_lr[LG_W] ? -n_qs : n_qs);
    assign n_le      = $signed(L_W'(lg_out)) <= r_l;
    assign n_refm1   = (r_ref == '0) ? '0 : r_ref - 1'b1;
    assign n_fsavg   = ADC_BITS'(FS) - ADC_BITS'(r_avg);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) n_state = ST_AVG;
            end
            ST_AVG: begin
                if (div_done) n_state = ST_CHK;
            end
            ST_CHK: begin
                if (mul_done) n_state = ST_NUM;
            end
            ST_NUM: begin
                if (mul_done) n_state = ST_DEN;
            end
            ST_DEN: begin
                if (r_floor || mul_done) n_state = ST_SPEC;
            end
            ST_SPEC: begin
                n_state = (r_num == '0 || r_den == '0) ? ST_DONE : ST_LGN;
            end
            ST_LGN: begin
                if (lg_done) n_state = ST_LGD;
            end
            ST_LGD: begin
                if (lg_done) n_state = ST_SCL;
            end
            ST_SCL: begin
                if (mul_done) n_state = ST_QDIV;
            end
            ST_QDIV: begin
                if (div_done) n_state = ST_RANGE;
            end
            ST_RANGE: begin
                n_state = (r_l < LO_L || r_l > HI_L) ? ST_DONE : ST_BS;
            end
            ST_BS: begin
                if (lg_done) n_state = ST_BSC;
            end
            ST_BSC: begin
                n_state = (r_lo < r_hi) ? ST_BS : ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        lg_start     = 1'b0;
        lg_x         = '0;
        unique case (r_state)
            ST_AVG: begin
                div_start    = launch;
                div_dividend = DIV_W'(r_sum);
                div_divisor  = DVS_W'(WINDOW);
            end
            ST_CHK: begin
                mul_start = launch;
                mul_a     = MUL_W'(r_avg);
                mul_b     = MUL_W'(r_ref);
            end
            ST_NUM: begin
                mul_start = launch;
                mul_a     = r_floor ? MUL_W'(n_refm1) : MUL_W'(n_fsavg);
                mul_b     = MUL_W'(r_rl);
            end
            ST_DEN: begin
                mul_start = launch && !r_floor;
                mul_a     = MUL_W'(r_avg);
                mul_b     = MUL_W'(r_r0);
            end
            ST_LGN: begin
                lg_start = launch;
                lg_x     = r_num;
            end
            ST_LGD: begin
                lg_start = launch;
                lg_x     = r_den;
            end
            ST_SCL: begin
                mul_start = launch;
                mul_a     = MUL_W'(EXP_NUM);
                mul_b     = MUL_W'(n_abs);
            end
            ST_QDIV: begin
                div_start    = launch;
                div_dividend = r_prod;
                div_divisor  = DVS_W'(EXP_DEN);
            end
            ST_BS: begin
                lg_start = launch;
                lg_x     = LG_IN_W'(n_mid);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= (n_state == r_state);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= REF_W'(REF_RESET);
            r_rl  <= RL_W'(RL_RESET);
            r_r0  <= R0_W'(R0_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_REF_MV: r_ref <= i_cfg_data[REF_W-1:0];
                CFG_LOAD:   r_rl  <= i_cfg_data[RL_W-1:0];
                CFG_CLEAN:  r_r0  <= i_cfg_data[R0_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_win[i] <= '0;
            end
            r_pos     <= '0;
            r_sum     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_sum        <= r_sum - SUM_W'(r_win[r_pos]) + SUM_W'(n_sample);
                r_win[r_pos] <= n_sample;
                r_pos        <= (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + 1'b1;
            end
            if (r_state == ST_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_AVG: begin
                if (div_done) r_avg <= div_q[SAMPLE_W-1:0];
            end
            ST_CHK: begin
                if (mul_done) r_floor <= (mul_p <= PROD_W'(FS));
            end
            ST_NUM: begin
                if (mul_done) r_num <= mul_p[LG_IN_W-1:0];
            end
            ST_DEN: begin
                if (r_floor) begin
                    r_den <= LG_IN_W'(r_r0);
                end else if (mul_done) begin
                    r_den <= mul_p[LG_IN_W-1:0];
                end
            end
            ST_SPEC: begin
                if (r_num == '0) begin
                    r_ppm   <= PPM_W'(PPM_HI_X16);
                    r_clamp <= CLAMP_HIGH;
                end else if (r_den == '0) begin
                    r_ppm   <= PPM_W'(PPM_LO_X16);
                    r_clamp <= CLAMP_LOW;
                end
            end
            ST_LGN: begin
                if (lg_done) r_lgn <= lg_out;
            end
            ST_LGD: begin
                if (lg_done) r_lr <= n_lr;
            end
            ST_SCL: begin
                if (mul_done) r_prod <= mul_p[DIV_W-1:0];
            end
            ST_QDIV: begin
                if (div_done) r_l <= n_lval;
            end
            ST_RANGE: begin
                if (r_l < LO_L) begin
                    r_ppm   <= PPM_W'(PPM_LO_X16);
                    r_clamp <= CLAMP_LOW;
                end else if (r_l > HI_L) begin
                    r_ppm   <= PPM_W'(PPM_HI_X16);
                    r_clamp <= CLAMP_HIGH;
                end
                r_lo <= PPM_W'(PPM_LO_X16);
                r_hi <= PPM_W'(PPM_HI_X16);
            end
            ST_BS: begin
                if (lg_done) begin
                    if (n_le) begin
                        r_lo <= n_mid;
                    end else begin
                        r_hi <= n_mid - 1'b1;
                    end
                end
            end
            ST_BSC: begin
                if (!(r_lo < r_hi)) begin
                    r_ppm   <= r_lo;
                    r_clamp <= CLAMP_IN;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_o_avg   <= r_avg;
                    r_o_ppm   <= r_ppm;
                    r_o_clamp <= r_clamp;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = M_DATA_W'({r_o_clamp, r_o_ppm, r_o_avg});

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("sample accepted while previous one in progress");

    a_ppm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_o_ppm >= PPM_W'(PPM_LO_X16) && r_o_ppm <= PPM_W'(PPM_HI_X16)))
        else $error("ppm result outside clamp range");

    a_low_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_o_clamp == CLAMP_LOW) |-> (r_o_ppm == PPM_W'(PPM_LO_X16)))
        else $error("low clamp without low ppm value");

    a_bs_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BS) |-> (r_lo <= r_hi))
        else $error("search bounds crossed");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} < (POS_W + 1)'(WINDOW))
        else $error("window position out of range");

endmodule

### tb/moving_average_gas_ppm_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// moving_average_gas_ppm_tb
// Streams ADC samples through the gas ppm block under random flow control
// and checks every result against an in-bench model of the window filter
// and the fixed-point power-law calibration, over several register settings.
// ---------------------------------------------------------------------------
module moving_average_gas_ppm_tb;
    import mav_pkg::*;

    localparam int  WIN        = DEF_WINDOW;
    localparam int  FULL_SCALE = (1 << DEF_ADC_BITS) - 1;
    localparam longint CYCLE_LIMIT = 64'd80_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CLAMP_W-1:0]  clamp;
        logic [PPM_W-1:0]    ppm_x16;
        logic [SAMPLE_W-1:0] avg;
    } t_reading;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    moving_average_gas_ppm dut (.*);

    always #1 i_clk = ~i_clk;

    // model state
    logic [SAMPLE_W-1:0] win_q [WIN];
    int unsigned         win_pos;
    int unsigned         win_sum;
    longint unsigned     ref_mv, load_ohm, clean_ohm;
    t_reading            readings_q[$];

    int     errors;
    int     n_samples, n_in_range, n_low, n_high;
    longint cycles;
    bit     idle_on;
    int     hold_cycles;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("moving_average_gas_ppm: mismatch");
            $finish;
        end
    end

    function automatic longint ppm_lg2_q16(input longint unsigned x);
        int unsigned     n;
        longint unsigned m;
        longint          frac;
        n = 0;
        frac = 0;
        if (x == 0) return 0;
        while (n < 63 && (x >> (n + 1)) != 0) n++;
        m = (n <= 31) ? (x << (31 - n)) : (x >> (n - 31));
        for (int k = 0; k < LG_STEPS; k++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return longint'(n) * 65536 + frac;
    endfunction

    function automatic t_reading calibrate(input longint unsigned avg);
        t_reading        r;
        longint unsigned num, den, lo, hi, mid;
        longint          lr, lval;
        r.avg = avg[SAMPLE_W-1:0];
        if (avg * ref_mv <= FULL_SCALE) begin
            num = (ref_mv >= 1) ? (ref_mv - 1) * load_ohm : 0;
            den = clean_ohm;
        end else begin
            num = (FULL_SCALE - avg) * load_ohm;
            den = avg * clean_ohm;
        end
        if (num == 0) begin
            r.ppm_x16 = PPM_W'(PPM_HI_X16);
            r.clamp = CLAMP_HIGH;
            return r;
        end
        if (den == 0) begin
            r.ppm_x16 = PPM_W'(PPM_LO_X16);
            r.clamp = CLAMP_LOW;
            return r;
        end
        lr = ppm_lg2_q16(num) - ppm_lg2_q16(den);
        lval = ppm_lg2_q16(PPM_K_X160) - ppm_lg2_q16(PPM_K_DIV)
             - (longint'(EXP_NUM) * lr) / EXP_DEN;
        if (lval < ppm_lg2_q16(PPM_LO_X16)) begin
            r.ppm_x16 = PPM_W'(PPM_LO_X16);
            r.clamp = CLAMP_LOW;
            return r;
        end
        if (lval > ppm_lg2_q16(PPM_HI_X16)) begin
            r.ppm_x16 = PPM_W'(PPM_HI_X16);
            r.clamp = CLAMP_HIGH;
            return r;
        end
        lo = PPM_LO_X16;
        hi = PPM_HI_X16;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (ppm_lg2_q16(mid) <= lval) lo = mid;
            else hi = mid - 1;
        end
        r.ppm_x16 = lo[PPM_W-1:0];
        r.clamp = CLAMP_IN;
        return r;
    endfunction

    function automatic void window_push(input logic [SAMPLE_W-1:0] s);
        win_sum = win_sum - win_q[win_pos] + s;
        win_q[win_pos] = s;
        win_pos = (win_pos + 1 >= WIN) ? 0 : win_pos + 1;
        readings_q.push_back(calibrate(win_sum / WIN));
    endfunction

    function automatic int draw_gap();
        if (!idle_on) return 0;
        return $urandom_range(0, 13);
    endfunction

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("error at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    endtask

    // one sample transaction; valid stays high between back-to-back samples
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {{(S_DATA_W-SAMPLE_W){1'b0}}, s};
        do @(negedge i_clk); while (!o_s_tready);
        @(posedge i_clk);
        window_push(s);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (readings_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // valid stays high between back-to-back writes; the caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        case (idx)
            CFG_REF_MV: ref_mv = val & 20'h01FFF;
            CFG_LOAD:   load_ohm = val & 20'h1FFFF;
            CFG_CLEAN:  clean_ohm = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input int rmv, input int rl, input int r0);
        drain();
        write_reg(CFG_REF_MV, rmv[CFG_DATA_W-1:0]);
        write_reg(CFG_LOAD, rl[CFG_DATA_W-1:0]);
        write_reg(CFG_CLEAN, r0[CFG_DATA_W-1:0]);
        i_cfg_valid <= 1'b0;
    endtask

    // result side
    initial begin
        int       gap;
        t_reading got, want;
        forever begin
            if (hold_cycles > 0) begin
                i_m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            gap = draw_gap();
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(negedge i_clk); while (!o_m_tvalid || !i_rst_n);
            got = o_m_tdata[$bits(t_reading)-1:0];
            @(posedge i_clk);
            n_samples++;
            if (readings_q.size() == 0) begin
                report("unexpected result, avg", got.avg, 0);
            end else begin
                want = readings_q.pop_front();
                if (got.avg !== want.avg) report("avg_count", got.avg, want.avg);
                if (got.ppm_x16 !== want.ppm_x16) report("ppm_x16", got.ppm_x16, want.ppm_x16);
                if (got.clamp !== want.clamp) report("clamp_state", got.clamp, want.clamp);
                case (want.clamp)
                    CLAMP_IN:  n_in_range++;
                    CLAMP_LOW: n_low++;
                    default:   n_high++;
                endcase
            end
        end
    end

    task automatic test_window_fill();
        // zeros in the window pull the first averages down
        send_sample(12'd0);
        send_sample(12'hFFF);
        send_sample(12'hAAA);
        send_sample(12'h555);
        send_sample(12'd1);
        repeat (5) send_sample(12'hFFF);
        repeat (5) send_sample(12'd0);
        repeat (5) send_sample(12'd600);
    endtask

    task automatic test_special_regs();
        set_regs(3300, 10000, 0);
        repeat (2) send_sample(12'd600);
        set_regs(1, 10000, 76630);
        repeat (2) send_sample(12'd600);
        set_regs(0, 10000, 76630);
        send_sample(12'd3000);
        set_regs(3300, 0, 76630);
        send_sample(12'd3000);
        drain();
        write_reg(CFG_UNUSED, 20'h00123);
        write_reg(CFG_REF_MV, 20'hFFFFF);
        write_reg(CFG_LOAD, 20'hFFFFF);
        write_reg(CFG_CLEAN, 20'hFFFFF);
        i_cfg_valid <= 1'b0;
        repeat (3) send_sample(12'd50);
        set_regs(3300, 10000, 76630);
        repeat (5) send_sample(12'd1);
    endtask

    task automatic test_backpressure();
        drain();
        hold_cycles = 40000;
        repeat (6) send_sample(12'($urandom_range(200, 1200)));
    endtask

    task automatic test_random(input int count);
        int level, s, k;
        k = 0;
        while (k < count) begin
            if (k % 150 == 0) begin
                case ($urandom_range(0, 5))
                    0: set_regs(1000, 100, 1000);
                    1: set_regs(5000, 100000, 1000000);
                    2: set_regs(5000, 100, 1000000);
                    3: set_regs(1000, 100000, 1000);
                    default: set_regs($urandom_range(1000, 5000), $urandom_range(100, 100000),
                                      $urandom_range(1000, 1000000));
                endcase
            end
            if (k % 100 == 0) idle_on = $urandom_range(0, 3) != 0;
            if (k % 20 == 0) begin
                level = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                    : $urandom_range(100, 1400);
            end
            case ($urandom_range(0, 9))
                0:       s = $urandom_range(0, 4095);
                1:       s = ($urandom_range(0, 1) != 0) ? 4095 : 0;
                default: begin
                    s = level + $urandom_range(0, 160) - 80;
                    if (s < 0) s = 0;
                    if (s > 4095) s = 4095;
                end
            endcase
            send_sample(s[SAMPLE_W-1:0]);
            k++;
        end
    endtask

    initial begin
        for (int i = 0; i < WIN; i++) win_q[i] = '0;
        win_pos = 0;
        win_sum = 0;
        ref_mv = REF_RESET;
        load_ohm = RL_RESET;
        clean_ohm = R0_RESET;
        errors = 0;
        cycles = 0;
        hold_cycles = 0;
        n_samples = 0;
        n_in_range = 0;
        n_low = 0;
        n_high = 0;
        idle_on = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_window_fill();
        test_special_regs();
        test_backpressure();
        test_random(1200);
        drain();

        $display("checked %0d results: %0d in range, %0d clamped low, %0d clamped high",
                 n_samples, n_in_range, n_low, n_high);
        $display("register settings included extremes, masking and an unused index");
        if (errors == 0 && readings_q.size() == 0) begin
            $display("moving_average_gas_ppm: match");
        end else begin
            $display("moving_average_gas_ppm: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
sv/mav_pkg.sv
sv/mav_mul.sv
sv/mav_div.sv
sv/mav_lg.sv
sv/moving_average_gas_ppm.sv
tb/moving_average_gas_ppm_tb.sv
